>>> rtl/gcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcl_pkg
// Shared types and constants for the gimbal grid calibration lookup.
// ----------------------------------------------------------------------------
package gcl_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 512;
  localparam int unsigned YAW_W   = 9;
  localparam int unsigned PITCH_W = 10;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned ENTRY_W = YAW_W + PITCH_W + 2 * COORD_W;

  localparam logic [YAW_W-1:0]   YAW_LIMIT   = 9'd500;
  localparam logic [PITCH_W-1:0] PITCH_LIMIT = 10'd750;
  localparam logic signed [COORD_W-1:0] INVALID_COORD = -16'sd16;

  // input modes
  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_POINT = 3'd1;
  localparam logic [2:0] MODE_TICK  = 3'd2;
  localparam logic [2:0] MODE_ABORT = 3'd3;
  localparam logic [2:0] MODE_QUERY = 3'd4;

  // result events
  localparam logic [2:0] EV_MOVE     = 3'd0;
  localparam logic [2:0] EV_DONE     = 3'd1;
  localparam logic [2:0] EV_FULL     = 3'd2;
  localparam logic [2:0] EV_ABORTED  = 3'd3;
  localparam logic [2:0] EV_QUERY_OK = 3'd4;
  localparam logic [2:0] EV_NO_TABLE = 3'd5;
  localparam logic [2:0] EV_NO_VALID = 3'd6;

  // register indexes
  localparam logic [2:0] REG_YAW_START    = 3'd0;
  localparam logic [2:0] REG_YAW_END      = 3'd1;
  localparam logic [2:0] REG_YAW_STRIDE   = 3'd2;
  localparam logic [2:0] REG_PITCH_START  = 3'd3;
  localparam logic [2:0] REG_PITCH_END    = 3'd4;
  localparam logic [2:0] REG_PITCH_STRIDE = 3'd5;
  localparam logic [2:0] REG_TIMEOUT      = 3'd6;

  typedef struct packed {
    logic [2:0]                mode;
    logic signed [COORD_W-1:0] laser_x;
    logic signed [COORD_W-1:0] laser_y;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [YAW_W-1:0]   yaw_target;
    logic [PITCH_W-1:0] pitch_target;
    logic [CNT_W-1:0]   count_or_index;
  } res_t;

  typedef struct packed {
    logic [YAW_W-1:0]          yaw;
    logic [PITCH_W-1:0]        pitch;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } entry_t;

endpackage

>>> rtl/gimbal_grid_calibration_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gimbal_grid_calibration_lookup
// Serpentine grid scan with sample capture and nearest-sample lookup.
// ----------------------------------------------------------------------------
// Scan commands (start, point, tick, abort) answer with at most one result
// beat. A nearest query reads the sample table one entry per cycle through
// the single RAM port, then runs a 3-stage distance pipeline. busy is high
// from acceptance until the cycle that carries the result beat. Result beats
// are single-cycle strobes; the receiver cannot stall them. The table needs
// no clearing after reset.
// ----------------------------------------------------------------------------
module gimbal_grid_calibration_lookup #(
  parameter int unsigned TABLE_DEPTH = gcl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  gcl_pkg::cmd_t         cmd,
  output logic                  done,
  output gcl_pkg::res_t         res,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [gcl_pkg::CFG_W-1:0] cfg_data
);

  import gcl_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned RAM_D = (TABLE_DEPTH > 1) ? TABLE_DEPTH : 2;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_QREAD = 5'b00100,
    ST_QDRN  = 5'b01000,
    ST_QOUT  = 5'b10000
  } state_t;

  state_t state;
  cmd_t   cur;

  // configuration
  logic [YAW_W-1:0]   yaw_start, yaw_end, yaw_stride;
  logic [PITCH_W-1:0] pitch_start, pitch_end, pitch_stride;
  logic [15:0]        timeout_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_start <= '0; yaw_end <= YAW_LIMIT; yaw_stride <= YAW_W'(1);
      pitch_start <= '0; pitch_end <= PITCH_LIMIT; pitch_stride <= PITCH_W'(1);
      timeout_ticks <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_YAW_START:    yaw_start <= cfg_data[YAW_W-1:0];
        REG_YAW_END:      yaw_end <= cfg_data[YAW_W-1:0];
        REG_YAW_STRIDE:   yaw_stride <= cfg_data[YAW_W-1:0];
        REG_PITCH_START:  pitch_start <= cfg_data[PITCH_W-1:0];
        REG_PITCH_END:    pitch_end <= cfg_data[PITCH_W-1:0];
        REG_PITCH_STRIDE: pitch_stride <= cfg_data[PITCH_W-1:0];
        REG_TIMEOUT:      timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan state
  logic scan_active, awaiting_point, row_forward;
  logic [YAW_W-1:0]   current_yaw;
  logic [PITCH_W-1:0] current_pitch;
  logic [15:0]        wait_counter;
  logic [CNT_W-1:0]   sample_count;

  // clamped grid corners
  logic [YAW_W-1:0]   ys, ye;
  logic [PITCH_W-1:0] ps, pe;
  assign ys = (yaw_start > YAW_LIMIT) ? YAW_LIMIT : yaw_start;
  assign ye = (yaw_end > YAW_LIMIT) ? YAW_LIMIT : yaw_end;
  assign ps = (pitch_start > PITCH_LIMIT) ? PITCH_LIMIT : pitch_start;
  assign pe = (pitch_end > PITCH_LIMIT) ? PITCH_LIMIT : pitch_end;

  // next grid pose (signed 12-bit math)
  logic yup, pup, go_up, yaw_ok, pitch_ok;
  logic signed [11:0] ny, np, ylim;
  always_comb begin
    yup   = ye >= ys;
    pup   = pe >= ps;
    go_up = row_forward ? yup : !yup;
    ylim  = row_forward ? $signed({3'b0, ye}) : $signed({3'b0, ys});
    ny = go_up ? $signed({3'b0, current_yaw}) + $signed({3'b0, yaw_stride})
               : $signed({3'b0, current_yaw}) - $signed({3'b0, yaw_stride});
    yaw_ok = go_up ? (ny <= ylim) : (ny >= ylim);
    np = pup ? $signed({2'b0, current_pitch}) + $signed({2'b0, pitch_stride})
             : $signed({2'b0, current_pitch}) - $signed({2'b0, pitch_stride});
    pitch_ok = pup ? (np <= $signed({2'b0, pe})) : (np >= $signed({2'b0, pe}));
  end

  // RAM
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  entry_t           ram_wdata, ram_rdata;

  gcl_ram #(.WIDTH(ENTRY_W), .DEPTH(RAM_D)) u_table (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // query pipeline: read -> diff -> squares -> sum/compare
  logic [CNT_W-1:0] rd_idx;
  logic             p1_v, p2_v, p3_v;
  logic [CNT_W-1:0] p1_i, p2_i, p3_i;
  logic signed [COORD_W:0] dx, dy;
  logic             p2_ok, p3_ok;
  logic [2*COORD_W+1:0] sqx, sqy;
  logic [YAW_W-1:0]   p2_yaw, p3_yaw;
  logic [PITCH_W-1:0] p2_pitch, p3_pitch;
  logic [2*COORD_W+2:0] sq_dist, best_d;
  logic [CNT_W-1:0]   best_i;
  logic [YAW_W-1:0]   best_yaw;
  logic [PITCH_W-1:0] best_pitch;
  logic               found;

  assign sq_dist = {1'b0, sqx} + {1'b0, sqy};

  // write / read addressing
  logic close_ev;
  logic [15:0] wc_inc;
  assign wc_inc = (wait_counter == 16'hFFFF) ? wait_counter : wait_counter + 16'd1;

  always_comb begin
    ram_we = 1'b0;
    ram_addr = rd_idx[AW-1:0];
    ram_wdata = '{yaw: current_yaw, pitch: current_pitch,
                  x: cur.laser_x, y: cur.laser_y};
    close_ev = 1'b0;
    if (state == ST_EXEC && scan_active && awaiting_point) begin
      if (cur.mode == MODE_POINT) close_ev = 1'b1;
      if (cur.mode == MODE_TICK && wc_inc >= timeout_ticks) close_ev = 1'b1;
    end
    if (cur.mode == MODE_TICK) begin
      ram_wdata.x = INVALID_COORD;
      ram_wdata.y = INVALID_COORD;
    end
    if (close_ev && sample_count < DEPTH_C) begin
      ram_we = 1'b1;
      ram_addr = sample_count[AW-1:0];
    end
  end

  assign busy = (state != ST_IDLE);

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      scan_active <= 1'b0; awaiting_point <= 1'b0; row_forward <= 1'b1;
      current_yaw <= '0; current_pitch <= '0;
      wait_counter <= '0; sample_count <= '0;
      done <= 1'b0;
      p1_v <= 1'b0; p2_v <= 1'b0; p3_v <= 1'b0;
      found <= 1'b0;
    end else begin
      done <= 1'b0;
      res <= '0;
      p1_v <= 1'b0;
      p2_v <= p1_v;
      p3_v <= p2_v;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cur <= cmd;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
          priority if (cur.mode == MODE_START) begin
            if (yaw_stride != '0 && pitch_stride != '0) begin
              sample_count <= '0; scan_active <= 1'b1; row_forward <= 1'b1;
              current_yaw <= ys; current_pitch <= ps;
              awaiting_point <= 1'b1; wait_counter <= '0;
              done <= 1'b1;
              res <= '{event_res: EV_MOVE, yaw_target: ys, pitch_target: ps,
                       count_or_index: '0};
            end
          end else if (cur.mode == MODE_POINT || cur.mode == MODE_TICK) begin
            if (scan_active && awaiting_point && cur.mode == MODE_TICK)
              wait_counter <= wc_inc;
            if (close_ev) begin
              done <= 1'b1;
              if (sample_count >= DEPTH_C) begin
                scan_active <= 1'b0; awaiting_point <= 1'b0;
                res <= '{event_res: EV_FULL, default: '0};
              end else begin
                sample_count <= sample_count + CNT_W'(1);
                if (yaw_ok) begin
                  current_yaw <= ny[YAW_W-1:0];
                  wait_counter <= '0;
                  res <= '{event_res: EV_MOVE, yaw_target: ny[YAW_W-1:0],
                           pitch_target: current_pitch, count_or_index: '0};
                end else if (pitch_ok) begin
                  current_pitch <= np[PITCH_W-1:0];
                  row_forward <= !row_forward;
                  wait_counter <= '0;
                  res <= '{event_res: EV_MOVE, yaw_target: current_yaw,
                           pitch_target: np[PITCH_W-1:0], count_or_index: '0};
                end else begin
                  scan_active <= 1'b0; awaiting_point <= 1'b0;
                  res <= '{event_res: EV_DONE, yaw_target: '0, pitch_target: '0,
                           count_or_index: sample_count + CNT_W'(1)};
                end
              end
            end
          end else if (cur.mode == MODE_ABORT) begin
            scan_active <= 1'b0; awaiting_point <= 1'b0;
            done <= 1'b1;
            res <= '{event_res: EV_ABORTED, default: '0};
          end else if (cur.mode == MODE_QUERY) begin
            if (sample_count == '0) begin
              done <= 1'b1;
              res <= '{event_res: EV_NO_TABLE, default: '0};
            end else begin
              rd_idx <= '0;
              found <= 1'b0;
              state <= ST_QREAD;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_QREAD: begin
          p1_v <= 1'b1;
          p1_i <= rd_idx;
          if (rd_idx + CNT_W'(1) >= sample_count) state <= ST_QDRN;
          rd_idx <= rd_idx + CNT_W'(1);
        end
        ST_QDRN: begin
          if (!p1_v && !p2_v && !p3_v) state <= ST_QOUT;
        end
        ST_QOUT: begin
          state <= ST_IDLE;
          done <= 1'b1;
          if (found)
            res <= '{event_res: EV_QUERY_OK, yaw_target: best_yaw,
                     pitch_target: best_pitch, count_or_index: best_i};
          else
            res <= '{event_res: EV_NO_VALID, default: '0};
        end
        default: state <= ST_IDLE;
      endcase
      // best tracking, stage 3
      if (p3_v && p3_ok && (!found || sq_dist < best_d)) begin
        found <= 1'b1;
        best_d <= sq_dist;
        best_i <= p3_i;
        best_yaw <= p3_yaw;
        best_pitch <= p3_pitch;
      end
    end
  end

  // query datapath, stages 1 and 2
  always_ff @(posedge clk) begin
    dx <= $signed({ram_rdata.x[COORD_W-1], ram_rdata.x})
        - $signed({cur.laser_x[COORD_W-1], cur.laser_x});
    dy <= $signed({ram_rdata.y[COORD_W-1], ram_rdata.y})
        - $signed({cur.laser_y[COORD_W-1], cur.laser_y});
    p2_ok <= !ram_rdata.x[COORD_W-1] && !ram_rdata.y[COORD_W-1];
    p2_i <= p1_i;
    p2_yaw <= ram_rdata.yaw;
    p2_pitch <= ram_rdata.pitch;
    // squares at full width, operands sign-extended first
    sqx <= $unsigned((2*COORD_W+2)'(dx) * (2*COORD_W+2)'(dx));
    sqy <= $unsigned((2*COORD_W+2)'(dy) * (2*COORD_W+2)'(dy));
    p3_ok <= p2_ok;
    p3_i <= p2_i;
    p3_yaw <= p2_yaw;
    p3_pitch <= p2_pitch;
  end

endmodule

>>> rtl/gcl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcl_ram
// Single-port synchronous RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module gcl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/gcl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcl_checker
// Port-level checks for the gimbal grid calibration lookup.
// ----------------------------------------------------------------------------
module gcl_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input gcl_pkg::res_t  res
);

  import gcl_pkg::*;

  // accepted command makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised");

  // no result without a command in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without command");

  // event codes stay in range
  a_ev: assert property (@(posedge clk) disable iff (rst)
    done |-> res.event_res <= EV_NO_VALID) else $error("bad event");

  // pose only for move and query results
  a_pose: assert property (@(posedge clk) disable iff (rst)
    done && res.event_res != EV_MOVE && res.event_res != EV_QUERY_OK
    |-> res.yaw_target == '0 && res.pitch_target == '0) else $error("stray pose");

endmodule

bind gimbal_grid_calibration_lookup gcl_checker u_gcl_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .done(done), .res(res)
);
